// ----- rtl/core/cia_pkg.sv -----
// Shared types and constants of the interval timer and interrupt block.
// Holds the register map, control and flag bit positions and the item types.
// No dependencies.
`default_nettype none

package cia_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // Item kinds
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register map
  localparam logic [3:0] REG_PRB  = 4'h1;
  localparam logic [3:0] REG_TALO = 4'h4;
  localparam logic [3:0] REG_TAHI = 4'h5;
  localparam logic [3:0] REG_TBLO = 4'h6;
  localparam logic [3:0] REG_TBHI = 4'h7;
  localparam logic [3:0] REG_SDR  = 4'hC;
  localparam logic [3:0] REG_ICR  = 4'hD;
  localparam logic [3:0] REG_CRA  = 4'hE;
  localparam logic [3:0] REG_CRB  = 4'hF;

  // Control register bits
  localparam int CR_START   = 0;
  localparam int CR_ONESHOT = 3;
  localparam int CR_LOAD    = 4;
  localparam int CRA_INMODE = 5;

  // Timer B input source (control B bits 6..5)
  localparam logic [1:0] SRC_CYCLES = 2'b00;
  localparam logic [1:0] SRC_CNT    = 2'b01;

  // Interrupt flag bits
  localparam int FLAG_TA = 0;
  localparam int FLAG_TB = 1;
  localparam int FLAG_SP = 3;
  localparam int FLAG_IR = 7;

  localparam logic [7:0] FLAG_TICK_MASK = 8'h0f;
  localparam logic [7:0] MASK_BITS      = 8'h1f;
  localparam logic [7:0] ICR_READ_MASK  = 8'h9f;

  localparam logic [15:0] TIMER_RESET = 16'hffff;

  // One input item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  reg_address;
    logic [7:0]  write_data;
    logic [15:0] elapsed_cycles;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cia_timer.sv -----
// Down-counter step of one 16-bit interval timer.
// Subtracts a step count and reloads from the latch minus the overshoot.
// Depends on nothing but plain logic.
`default_nettype none

module cia_timer (
  input  logic [15:0] count,
  input  logic [15:0] latch,
  input  logic [15:0] step,
  output logic [15:0] count_next,
  output logic        underflow
);

  // Underflow when the step exceeds the count; reload is latch - (step - count)
  always_comb begin
    underflow = (step > count);
    if (underflow) begin
      count_next = latch - step + count;
    end else begin
      count_next = count - step;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cia_regs.sv -----
// Register file, timers and interrupt control of the block.
// Applies one item per enabled cycle and gives the result combinationally.
// Depends on cia_pkg and cia_timer.
`default_nettype none

module cia_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cia_pkg::item_t   item,
  output cia_pkg::result_t result
);

  import cia_pkg::*;

  logic [15:0] count_a, count_b, latch_a, latch_b;
  logic [7:0]  control_a, control_b, irq_flags, irq_mask;
  logic [7:0]  plain_regs [16];

  logic [15:0] count_a_next, count_b_next, latch_a_next, latch_b_next;
  logic [7:0]  control_a_next, control_b_next, irq_flags_next, irq_mask_next;
  logic        plain_we;
  logic [7:0]  read_data;

  logic [15:0] ta_count, tb_count, tb_step;
  logic        ta_under_raw, tb_under_raw, ta_active, tb_active, under_a;
  logic [1:0]  tb_src;
  logic [7:0]  v;

  assign v = item.write_data;

  // Timer A counts cycles only when started and not set to the CNT pin
  assign ta_active = control_a[CR_START] && !control_a[CRA_INMODE];
  assign under_a   = ta_active && ta_under_raw;

  cia_timer u_timer_a (
    .count      (count_a),
    .latch      (latch_a),
    .step       (item.elapsed_cycles),
    .count_next (ta_count),
    .underflow  (ta_under_raw)
  );

  // Timer B source: cycles, CNT (idle, no edges) or timer A underflows
  assign tb_src    = control_b[6:5];
  assign tb_active = control_b[CR_START] && (tb_src != SRC_CNT);
  assign tb_step   = (tb_src == SRC_CYCLES) ? item.elapsed_cycles : {15'd0, under_a};

  cia_timer u_timer_b (
    .count      (count_b),
    .latch      (latch_b),
    .step       (tb_step),
    .count_next (tb_count),
    .underflow  (tb_under_raw)
  );

  // Next-state decode of one item
  always_comb begin
    count_a_next   = count_a;
    count_b_next   = count_b;
    latch_a_next   = latch_a;
    latch_b_next   = latch_b;
    control_a_next = control_a;
    control_b_next = control_b;
    irq_flags_next = irq_flags;
    irq_mask_next  = irq_mask;
    plain_we       = 1'b0;
    read_data      = 8'd0;

    unique case (item.cmd)
      CMD_TICK: begin
        if (ta_active) begin
          count_a_next = ta_count;
          if (ta_under_raw) begin
            irq_flags_next[FLAG_TA] = 1'b1;
            if (control_a[CR_ONESHOT]) control_a_next[CR_START] = 1'b0;
          end
        end
        if (tb_active) begin
          count_b_next = tb_count;
          if (tb_under_raw) begin
            irq_flags_next[FLAG_TB] = 1'b1;
            if (control_b[CR_ONESHOT]) control_b_next[CR_START] = 1'b0;
          end
        end
        if ((irq_flags_next & irq_mask & FLAG_TICK_MASK) != 8'd0) begin
          irq_flags_next[FLAG_IR] = 1'b1;
        end
      end
      CMD_READ: begin
        unique case (item.reg_address)
          REG_PRB:  read_data = 8'd0;
          REG_TALO: read_data = count_a[7:0];
          REG_TAHI: read_data = count_a[15:8];
          REG_TBLO: read_data = count_b[7:0];
          REG_TBHI: read_data = count_b[15:8];
          REG_ICR: begin
            read_data      = irq_flags & ICR_READ_MASK;
            irq_flags_next = 8'd0;
          end
          REG_CRA:  read_data = control_a;
          REG_CRB:  read_data = control_b;
          default:  read_data = plain_regs[item.reg_address];
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_address)
          REG_PRB: ;
          REG_TALO: latch_a_next = {latch_a[15:8], v};
          REG_TAHI: begin
            latch_a_next = {v, latch_a[7:0]};
            if (!control_a[CR_START]) count_a_next = {v, latch_a[7:0]};
          end
          REG_TBLO: latch_b_next = {latch_b[15:8], v};
          REG_TBHI: begin
            latch_b_next = {v, latch_b[7:0]};
            if (!control_b[CR_START]) count_b_next = {v, latch_b[7:0]};
          end
          REG_SDR: begin
            plain_we = 1'b1;
            irq_flags_next[FLAG_SP] = 1'b1;
            if (irq_mask[FLAG_SP]) irq_flags_next[FLAG_IR] = 1'b1;
          end
          REG_ICR: begin
            if (v[7]) begin
              irq_mask_next = irq_mask | (v & MASK_BITS);
              if ((irq_flags & irq_mask_next & MASK_BITS) != 8'd0) begin
                irq_flags_next[FLAG_IR] = 1'b1;
              end
            end else begin
              irq_mask_next = irq_mask & ~v;
            end
          end
          REG_CRA: begin
            control_a_next          = v;
            control_a_next[CR_LOAD] = 1'b0;
            if (v[CR_LOAD]) count_a_next = latch_a;
          end
          REG_CRB: begin
            control_b_next          = v;
            control_b_next[CR_LOAD] = 1'b0;
            if (v[CR_LOAD]) count_b_next = latch_b;
          end
          default: plain_we = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  assign result.read_data   = read_data;
  assign result.irq_pending = irq_flags_next[FLAG_IR];

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a   <= TIMER_RESET;
      count_b   <= TIMER_RESET;
      latch_a   <= TIMER_RESET;
      latch_b   <= TIMER_RESET;
      control_a <= 8'd0;
      control_b <= 8'd0;
      irq_flags <= 8'd0;
      irq_mask  <= 8'd0;
      for (int i = 0; i < 16; i++) plain_regs[i] <= 8'd0;
    end else if (en) begin
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      latch_a   <= latch_a_next;
      latch_b   <= latch_b_next;
      control_a <= control_a_next;
      control_b <= control_b_next;
      irq_flags <= irq_flags_next;
      irq_mask  <= irq_mask_next;
      if (plain_we) plain_regs[item.reg_address] <= v;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cia_interval_timers_and_interrupts_core.sv -----
// Interval timers and interrupt control of a 6526-style peripheral block.
// Input stream: one item per accepted beat. s_axis_tuser carries the kind
// (tick, register read, register write); s_axis_tdata carries the register
// number, the write byte and, on ticks, the count of elapsed clock cycles.
// Output stream: exactly one result item per input item, in order, holding
// the byte read (zero for ticks and writes) and the interrupt summary bit.
// Timing: the input register takes the item at the accepting edge, and the
// result register loads from it when the item moves on, which a stalled
// receiver can hold back.
// Throughput: one item per cycle while the receiver takes results; the whole
// register and timer update for an item is combinational between those two
// registers, so the next item already sees the state the previous one left.
// Reset (rst, synchronous): timers and latches to 0xffff, control, flags,
// mask and storage to zero, both stream registers empty.
// When the receiver stalls the result register holds; the input register
// takes one more item, then s_axis_tready drops until the result is taken.
// Depends on cia_pkg, cia_regs and cia_timer.
`default_nettype none

module cia_interval_timers_and_interrupts_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] reg_address, [11:4] write_data, [27:12] elapsed_cycles, [31:28] zero
  input  logic [cia_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [cia_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] read_data, [8] irq_pending, [15:9] zero
  output logic [cia_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import cia_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t step_result;
  logic    advance;

  // An item moves on when the result register is free or being emptied
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd            <= s_axis_tuser[1:0];
      in_item.reg_address    <= s_axis_tdata[3:0];
      in_item.write_data     <= s_axis_tdata[11:4];
      in_item.elapsed_cycles <= s_axis_tdata[27:12];
    end
  end

  cia_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result <= step_result;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_result.irq_pending, out_result.read_data};

endmodule

`default_nettype wire
